[rtl/bale_pkg.sv]
// Shared types, operation codes and status codes for the bounded array list engine.
package bale_pkg;

  typedef logic signed [31:0] word_t;

  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_DELETE   = 3'd1;
  localparam logic [2:0] OP_LOCATE   = 3'd2;
  localparam logic [2:0] OP_RETRIEVE = 3'd3;
  localparam logic [2:0] OP_SORTED   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPOS   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // Source of a cell's next entry.
  localparam logic [1:0] WR_HOLD  = 2'd0;
  localparam logic [1:0] WR_LEFT  = 2'd1;
  localparam logic [1:0] WR_RIGHT = 2'd2;
  localparam logic [1:0] WR_VALUE = 2'd3;

  typedef struct packed {
    logic [1:0] wr_sel;   // where the entry comes from this cycle
    logic       load;     // copy entry and compare result into the scan chain
    logic       shift;    // move the scan chain one cell toward cell zero
    logic       ge_mode;  // compare is "entry >= value" instead of "entry == value"
  } cell_ctrl_t;

endpackage

[rtl/bale_cell.sv]
// One list cell: a stored entry, a local comparator and one stage of the scan chain.
module bale_cell (
  input  logic               clk,
  input  bale_pkg::cell_ctrl_t ctrl,
  input  bale_pkg::word_t    req_value,
  input  bale_pkg::word_t    left_entry,
  input  bale_pkg::word_t    right_entry,
  input  bale_pkg::word_t    next_dat,
  input  logic               next_flag,
  output bale_pkg::word_t    entry,
  output bale_pkg::word_t    dat,
  output logic               flag
);
  import bale_pkg::*;

  word_t entry_r, entry_nxt;
  word_t dat_r, dat_nxt;
  logic  flag_r, flag_nxt;
  logic  hit;

  always_comb begin
    unique case (ctrl.wr_sel)
      WR_HOLD:  entry_nxt = entry_r;
      WR_LEFT:  entry_nxt = left_entry;
      WR_RIGHT: entry_nxt = right_entry;
      WR_VALUE: entry_nxt = req_value;
      default:  entry_nxt = entry_r;
    endcase
  end

  assign hit = ctrl.ge_mode ? (entry_r >= req_value) : (entry_r == req_value);

  always_comb begin
    dat_nxt  = dat_r;
    flag_nxt = flag_r;
    if (ctrl.load) begin
      dat_nxt  = entry_r;
      flag_nxt = hit;
    end else if (ctrl.shift) begin
      dat_nxt  = next_dat;
      flag_nxt = next_flag;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    dat_r   <= dat_nxt;
    flag_r  <= flag_nxt;
  end

  assign entry = entry_r;
  assign dat   = dat_r;
  assign flag  = flag_r;

endmodule

[rtl/bounded_array_list_engine.sv]
// Top level of the bounded array list engine: request control and the row of list cells.
//
//   channel   ports                                             direction
//   in        in_valid, in_stall, in_opcode, in_position,       request in
//             in_value
//   out       out_valid, out_stall, out_status,                 result out
//             out_read_value, out_found_index, out_entry_count
//
// One request at a time: in_stall is high from acceptance until its result is loaded.
// A valid insert or delete passes through the load, apply and done states; a rejection
// goes from load straight to done. Locate and retrieve scan one position per cycle up to
// and including the match, the requested position or the list length; sorted insert scans
// every position up to and including the list length, then applies and loads. Synchronous
// active-low reset empties the list without clearing entries. A result held by
// out_stall keeps the next one in the done state, with in_stall high, until taken.
module bounded_array_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [2:0]      in_opcode,
  input  logic [4:0]      in_position,
  input  bale_pkg::word_t in_value,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_status,
  output bale_pkg::word_t out_read_value,
  output logic [3:0]      out_found_index,
  output logic [4:0]      out_entry_count
);
  import bale_pkg::*;

  // Count width holds 0 .. CAPACITY; the compare width also covers the position field.
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > 5) ? CW : 5;
  localparam logic [CW-1:0] CAP_L = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Request and working registers.
  logic [2:0]    op_r, op_nxt;
  logic [4:0]    pos_r, pos_nxt;
  word_t         val_r, val_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] ip_r, ip_nxt;
  logic [1:0]    st_r, st_nxt;
  word_t         rdv_r, rdv_nxt;
  logic [3:0]    fidx_r, fidx_nxt;

  // Output registers.
  logic [1:0]    ost_r, ost_nxt;
  word_t         ordv_r, ordv_nxt;
  logic [3:0]    ofidx_r, ofidx_nxt;
  logic [4:0]    ocnt_r, ocnt_nxt;

  logic          in_acc;
  logic          out_load;
  logic [MW-1:0] pos_ext, len_ext, k_ext, limit;
  logic [CW-1:0] apply_pos;

  cell_ctrl_t ctrl_w  [CAPACITY];
  word_t      entry_w [CAPACITY];
  word_t      dat_w   [CAPACITY];
  logic       flag_w  [CAPACITY];

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign pos_ext = MW'(pos_r);
  assign len_ext = MW'(len_r);
  assign k_ext   = MW'(k_r);
  // Retrieve walks to its position; locate and sorted insert are bounded by the list length.
  assign limit   = (op_r == OP_RETRIEVE) ? pos_ext : len_ext;
  // Sorted insert uses the slot found by the scan; the others use the request position,
  // which has already been checked against the list length.
  assign apply_pos = (op_r == OP_SORTED) ? ip_r : CW'(pos_r);

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    k_nxt         = k_r;
    ip_nxt        = ip_r;
    st_nxt        = st_r;
    rdv_nxt       = rdv_r;
    fidx_nxt      = fidx_r;
    ost_nxt       = ost_r;
    ordv_nxt      = ordv_r;
    ofidx_nxt     = ofidx_r;
    ocnt_nxt      = ocnt_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_opcode;
          pos_nxt   = in_position;
          val_nxt   = in_value;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        // Cells copy their entries and compare results into the scan chain this cycle.
        k_nxt    = '0;
        ip_nxt   = '0;
        st_nxt   = ST_OK;
        rdv_nxt  = '0;
        fidx_nxt = '0;
        unique case (op_r)
          OP_INSERT: begin
            if (pos_ext > len_ext) begin
              st_nxt    = ST_BADPOS;
              state_nxt = S_DONE;
            end else if (len_r == CAP_L) begin
              st_nxt    = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_APPLY;
            end
          end
          OP_DELETE: begin
            if (pos_ext >= len_ext) begin
              st_nxt    = ST_BADPOS;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_APPLY;
            end
          end
          OP_LOCATE: begin
            state_nxt = S_SCAN;
          end
          OP_RETRIEVE: begin
            if (pos_ext >= len_ext) begin
              st_nxt    = ST_BADPOS;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          OP_SORTED: begin
            if (len_r == CAP_L) begin
              st_nxt    = ST_FULL;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
            st_nxt    = ST_BADPOS;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        // Cell zero holds the flag and entry of list position k.
        k_nxt = k_r + 1'b1;
        if (k_ext == limit) begin
          if (op_r == OP_SORTED) begin
            state_nxt = S_APPLY;
          end else if (op_r == OP_RETRIEVE) begin
            rdv_nxt   = dat_w[0];
            state_nxt = S_DONE;
          end else begin
            st_nxt    = ST_NOTFOUND;
            state_nxt = S_DONE;
          end
        end else if (flag_w[0]) begin
          if (op_r == OP_LOCATE) begin
            fidx_nxt  = 4'(k_r);
            state_nxt = S_DONE;
          end else if (op_r == OP_SORTED) begin
            // The new value goes after the last entry that is not below it.
            ip_nxt = k_r + 1'b1;
          end
        end
      end
      S_APPLY: begin
        if (op_r == OP_DELETE) begin
          len_nxt = len_r - 1'b1;
        end else begin
          len_nxt = len_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          ost_nxt       = st_r;
          ordv_nxt      = rdv_r;
          ofidx_nxt     = fidx_r;
          ocnt_nxt      = 5'(len_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    k_r     <= k_nxt;
    ip_r    <= ip_nxt;
    st_r    <= st_nxt;
    rdv_r   <= rdv_nxt;
    fidx_r  <= fidx_nxt;
    ost_r   <= ost_nxt;
    ordv_r  <= ordv_nxt;
    ofidx_r <= ofidx_nxt;
    ocnt_r  <= ocnt_nxt;
  end

  // The cell row. Each cell decides its own move from its fixed index and the
  // broadcast apply position: cells above an insert take their left neighbor,
  // cells at and above a delete take their right neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t left_w, right_w, next_dat_w;
    logic  next_flag_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = entry_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w     = '0;
      assign next_dat_w  = '0;
      assign next_flag_w = 1'b0;
    end else begin : g_mid_r
      assign right_w     = entry_w[i+1];
      assign next_dat_w  = dat_w[i+1];
      assign next_flag_w = flag_w[i+1];
    end

    always_comb begin
      ctrl_w[i].wr_sel  = WR_HOLD;
      ctrl_w[i].load    = (state_r == S_LOAD);
      ctrl_w[i].shift   = (state_r == S_SCAN);
      ctrl_w[i].ge_mode = (op_r == OP_SORTED);
      if (state_r == S_APPLY) begin
        if (op_r == OP_DELETE) begin
          if (CW'(i) >= apply_pos) begin
            ctrl_w[i].wr_sel = WR_RIGHT;
          end
        end else if (CW'(i) > apply_pos) begin
          ctrl_w[i].wr_sel = WR_LEFT;
        end else if (CW'(i) == apply_pos) begin
          ctrl_w[i].wr_sel = WR_VALUE;
        end
      end
    end

    bale_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl_w[i]),
      .req_value   (val_r),
      .left_entry  (left_w),
      .right_entry (right_w),
      .next_dat    (next_dat_w),
      .next_flag   (next_flag_w),
      .entry       (entry_w[i]),
      .dat         (dat_w[i]),
      .flag        (flag_w[i])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_status      = ost_r;
  assign out_read_value  = ordv_r;
  assign out_found_index = ofidx_r;
  assign out_entry_count = ocnt_r;

`ifndef SYNTH
  // The list never grows past its capacity.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CAP_L)
    else $error("list length exceeds capacity");

  // The length moves only in the apply step.
  a_len_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_APPLY) |=> $stable(len_r))
    else $error("list length changed outside the apply step");

  // A full rejection reports a full list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_entry_count == 5'(CAPACITY)))
    else $error("full status with a list that is not full");

  // Only a successful retrieve returns data, only a successful locate an index.
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_value == '0 && out_found_index == '0))
    else $error("failed request carries read data or an index");
`endif

endmodule
